/* rtl/core/sfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Shared constants, types and helpers for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int FRAME_LEN      = 25;
   localparam int POS_W          = 5;
   localparam int FIRST_DATA_POS = 1;
   localparam int FLAG_POS       = 23;
   localparam int FOOTER_POS     = 24;
   localparam logic [7:0] HEADER_BYTE = 8'h0F;
   localparam logic [7:0] FOOTER_BYTE = 8'h00;
   localparam int FAILSAFE_BIT   = 3;
   localparam int LOST_BIT       = 2;
   localparam int MAX_CHANNELS   = 16;
   localparam int RAW_WIDTH      = 11;
   localparam int FRAC_BITS      = 14;
   localparam int ROUND_BIAS     = 8192;
   localparam int QUEUE_DEPTH    = 8;
   localparam int RAM_DEPTH      = 2 * FRAME_LEN;
   localparam int RAM_AW         = $clog2(RAM_DEPTH);

   typedef enum logic [1:0] {
      CSR_CHAN_CFG     = 2'd0,
      CSR_SCALE_GAIN   = 2'd1,
      CSR_SCALE_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        valid;
      logic        bank;
      logic [4:0]  nchan;
      logic        failsafe;
      logic        frame_lost;
      logic [15:0] lost;
   } launch_type;

   typedef struct packed {
      logic [3:0]  index;
      logic [15:0] value;
      logic        failsafe;
      logic        frame_lost;
      logic [15:0] lost;
      logic        last;
   } result_type;

   function automatic logic [RAM_AW-1:0] ram_addr(input logic bank,
                                                  input logic [POS_W-1:0] pos);
      logic [RAM_AW-1:0] base;
      base = bank ? RAM_AW'(FRAME_LEN) : '0;
      return base + RAM_AW'(pos);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/sfd_frame_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS frame buffer memory
// Two frame banks in one synchronous memory, one write and one read port.
// ----------------------------------------------------------------------------
module sfd_frame_ram
   import sfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [RAM_AW-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [RAM_AW-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem_ff [RAM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/sfd_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS framer
// Tracks the byte position, writes bytes into the frame memory, checks
// header and footer, counts bad frames and launches good frames.
// ----------------------------------------------------------------------------
module sfd_framer
   import sfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              req_gap_before,
   input  wire logic [4:0]        chan_cfg,
   input  wire logic              emit_busy,
   output logic                   wr_en,
   output logic      [RAM_AW-1:0] wr_addr,
   output launch_type             launch
);

   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic             wbank_ff, wbank_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic [7:0]       flags_ff, flags_in;
   logic [15:0]      bad_ff, bad_in;
   logic             accept, complete, good, bad_inc;
   logic [4:0]       nchan;

   assign req_ready = !(pos_ff == POS_W'(FOOTER_POS) && emit_busy);
   assign accept    = req_valid && req_ready;
   assign pos_eff   = req_gap_before ? '0 : pos_ff;
   assign complete  = pos_eff == POS_W'(FOOTER_POS);
   assign good      = hdr_ok_ff && (req_rx_byte == FOOTER_BYTE);
   assign bad_inc   = accept && ((req_gap_before && pos_ff != '0) || (complete && !good));
   assign nchan     = (chan_cfg > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : chan_cfg;

   assign wr_en   = accept;
   assign wr_addr = ram_addr(wbank_ff, pos_eff);

   always_comb begin
      launch.valid      = accept && complete && good;
      launch.bank       = wbank_ff;
      launch.nchan      = nchan;
      launch.failsafe   = flags_ff[FAILSAFE_BIT];
      launch.frame_lost = flags_ff[LOST_BIT];
      launch.lost       = bad_ff;
   end

   always_comb begin
      pos_in    = pos_ff;
      wbank_in  = wbank_ff;
      hdr_ok_in = hdr_ok_ff;
      flags_in  = flags_ff;
      bad_in    = bad_ff;
      if (accept) begin
         pos_in = complete ? '0 : pos_eff + POS_W'(1);
         if (pos_eff == '0) begin
            hdr_ok_in = req_rx_byte == HEADER_BYTE;
         end
         if (pos_eff == POS_W'(FLAG_POS)) begin
            flags_in = req_rx_byte;
         end
         if (complete && good) begin
            wbank_in = !wbank_ff;
            bad_in   = '0;
         end
      end
      if (bad_inc && bad_ff != 16'hFFFF) begin
         bad_in = bad_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         wbank_ff <= 1'b0;
         bad_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         wbank_ff <= wbank_in;
         bad_ff   <= bad_in;
      end
      hdr_ok_ff <= hdr_ok_in;
      flags_ff  <= flags_in;
   end

endmodule
`default_nettype wire

/* rtl/core/sfd_channel_unpack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS channel unpacker
// Reads the data bytes of a launched frame from memory, gathers 11-bit
// channels, scales them and pushes finished items into the result queue.
// ----------------------------------------------------------------------------
module sfd_channel_unpack
   import sfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire launch_type                          launch,
   input  wire logic [15:0]                         scale_gain,
   input  wire logic [15:0]                         scale_offset,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_count,
   output logic                                     busy,
   output logic                                     rd_en,
   output logic      [RAM_AW-1:0]                   rd_addr,
   input  wire logic [7:0]                          rd_data,
   output logic                                     push,
   output result_type                               push_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = RAW_WIDTH + 16 + 1;

   logic             busy_ff, busy_in;
   logic             bank_ff;
   logic [POS_W-1:0] addr_ff, addr_in, end_ff;
   logic [4:0]       nchan_ff, chan_ff, chan_in;
   logic             failsafe_ff, frame_lost_ff;
   logic [15:0]      lost_ff;
   logic [9:0]       acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             rd_vld_ff;
   logic             raw_vld_ff, raw_vld_in;
   logic [RAW_WIDTH-1:0] raw_ff, raw_in;
   logic [3:0]       raw_idx_ff, raw_idx_in;
   logic             raw_last_ff, raw_last_in;
   logic             prod_vld_ff;
   logic [PW-1:0]    prod_ff;
   logic [3:0]       prod_idx_ff;
   logic             prod_last_ff;
   logic [CW:0]      inflight;
   logic             issue, start;
   logic [7:0]       bits_total, bytes_needed;
   logic [17:0]      merged;
   logic [4:0]       cnt_sum;
   logic [PW-1:0]    rounded;

   assign inflight = (CW+1)'(queue_count) + (CW+1)'(rd_vld_ff) + (CW+1)'(raw_vld_ff)
                   + (CW+1)'(prod_vld_ff);
   assign issue    = busy_ff && (inflight < (CW+1)'(QUEUE_DEPTH));
   assign start    = launch.valid && launch.nchan != '0;
   assign busy     = busy_ff || rd_vld_ff || raw_vld_ff || prod_vld_ff;
   assign rd_en    = issue;
   assign rd_addr  = ram_addr(bank_ff, addr_ff);

   assign bits_total   = 8'(launch.nchan) * 8'(RAW_WIDTH);
   assign bytes_needed = (bits_total + 8'd7) >> 3;

   assign merged  = {8'b0, acc_ff} | ({10'b0, rd_data} << cnt_ff);
   assign cnt_sum = 5'(cnt_ff) + 5'd8;

   always_comb begin
      busy_in     = busy_ff;
      addr_in     = addr_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      chan_in     = chan_ff;
      raw_vld_in  = 1'b0;
      raw_in      = merged[RAW_WIDTH-1:0];
      raw_idx_in  = chan_ff[3:0];
      raw_last_in = (chan_ff + 5'd1) == nchan_ff;
      if (issue) begin
         addr_in = addr_ff + POS_W'(1);
         if (addr_ff == end_ff) begin
            busy_in = 1'b0;
         end
      end
      if (rd_vld_ff) begin
         if (cnt_sum >= 5'(RAW_WIDTH)) begin
            raw_vld_in = 1'b1;
            acc_in     = 10'(merged >> RAW_WIDTH);
            cnt_in     = 4'(cnt_sum - 5'(RAW_WIDTH));
            chan_in    = chan_ff + 5'd1;
         end else begin
            acc_in = merged[9:0];
            cnt_in = cnt_sum[3:0];
         end
      end
      if (start) begin
         busy_in = 1'b1;
         addr_in = POS_W'(FIRST_DATA_POS);
         acc_in  = '0;
         cnt_in  = '0;
         chan_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         raw_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rd_vld_ff   <= issue;
         raw_vld_ff  <= raw_vld_in;
         prod_vld_ff <= raw_vld_ff;
      end
      if (start) begin
         bank_ff       <= launch.bank;
         end_ff        <= bytes_needed[POS_W-1:0];
         nchan_ff      <= launch.nchan;
         failsafe_ff   <= launch.failsafe;
         frame_lost_ff <= launch.frame_lost;
         lost_ff       <= launch.lost;
      end
      addr_ff      <= addr_in;
      acc_ff       <= acc_in;
      cnt_ff       <= cnt_in;
      chan_ff      <= chan_in;
      raw_ff       <= raw_in;
      raw_idx_ff   <= raw_idx_in;
      raw_last_ff  <= raw_last_in;
      prod_ff      <= PW'(raw_ff) * PW'(scale_gain);
      prod_idx_ff  <= raw_idx_ff;
      prod_last_ff <= raw_last_ff;
   end

   assign rounded = (prod_ff + PW'(ROUND_BIAS)) >> FRAC_BITS;
   assign push    = prod_vld_ff;

   always_comb begin
      push_data.index      = prod_idx_ff;
      push_data.value      = rounded[15:0] + scale_offset;
      push_data.failsafe   = failsafe_ff;
      push_data.frame_lost = frame_lost_ff;
      push_data.lost       = lost_ff;
      push_data.last       = prod_last_ff;
   end

endmodule
`default_nettype wire

/* rtl/core/sfd_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS result queue
// Small first-in first-out queue that holds finished channel items.
// ----------------------------------------------------------------------------
module sfd_result_queue
   import sfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire result_type                       push_data,
   input  wire logic                             pop,
   output logic                                  out_valid,
   output result_type                            out_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   result_type   mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(do_pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/sbus_frame_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS frame decoder
// Gathers 25-byte SBUS frames and emits one scaled item per channel.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while req_ready is high. Bytes
// go into a two-bank frame memory, so a new frame fills one bank while the
// channels of the previous good frame are read from the other, one data byte
// per cycle while reads are not paused, through a multiply stage into a result
// queue of QUEUE_DEPTH items. A good frame with n channels reads ceil(11n/8)
// data bytes. The footer byte of the next frame waits while the unpacker is
// busy. Reads also pause while the queue and the pipeline together hold
// QUEUE_DEPTH items, which lengthens the unpack and so the footer wait.
module sbus_frame_decoder_unit
   import sfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_gap_before,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_channel_index,
   output logic [15:0]      rsp_channel_value,
   output logic             rsp_failsafe,
   output logic             rsp_frame_lost,
   output logic [15:0]      rsp_lost_frames,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [4:0]       chan_cfg_ff;
   logic [15:0]      scale_gain_ff, scale_offset_ff;
   logic             emit_busy, wr_en, rd_en, push;
   logic [RAM_AW-1:0] wr_addr, rd_addr;
   logic [7:0]       rd_data;
   logic [CW-1:0]    queue_count;
   launch_type       launch;
   result_type       push_data, out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff     <= 5'd8;
         scale_gain_ff   <= 16'd10240;
         scale_offset_ff <= 16'd880;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHAN_CFG:     chan_cfg_ff     <= csr_data[4:0];
            CSR_SCALE_GAIN:   scale_gain_ff   <= csr_data;
            CSR_SCALE_OFFSET: scale_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sfd_framer u_framer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .req_gap_before (req_gap_before),
      .chan_cfg       (chan_cfg_ff),
      .emit_busy      (emit_busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .launch         (launch)
   );

   sfd_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfd_channel_unpack #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_unpack (
      .clock        (clock),
      .reset        (reset),
      .launch       (launch),
      .scale_gain   (scale_gain_ff),
      .scale_offset (scale_offset_ff),
      .queue_count  (queue_count),
      .busy         (emit_busy),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .push         (push),
      .push_data    (push_data)
   );

   sfd_result_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (queue_count)
   );

   assign rsp_channel_index = out_data.index;
   assign rsp_channel_value = out_data.value;
   assign rsp_failsafe      = out_data.failsafe;
   assign rsp_frame_lost    = out_data.frame_lost;
   assign rsp_lost_frames   = out_data.lost;
   assign rsp_last          = out_data.last;

endmodule
`default_nettype wire

/* rtl/core/sfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS frame decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_channel_index,
   input wire logic [15:0] rsp_channel_value,
   input wire logic        rsp_last
);

   logic [3:0] exp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_idx_ff <= rsp_last ? 4'd0 : rsp_channel_index + 4'd1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_value))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_top_channel_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_index == 4'd15 |-> rsp_last)
      else $error("channel fifteen not marked last");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel_index == exp_idx_ff)
      else $error("channel items out of order");

endmodule

bind sbus_frame_decoder_unit sfd_checker u_sfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_channel_index (rsp_channel_index),
   .rsp_channel_value (rsp_channel_value),
   .rsp_last          (rsp_last)
);
`default_nettype wire

/* verif/sbus_frame_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SBUS frame decoder testbench
// Streams SBUS frames, some well formed and some broken, into the decoder
// under several scale and channel settings. A scoreboard rebuilds each frame
// and predicts every channel item, which is then checked against the outputs.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit_tb;
   import sfd_pkg::*;

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int IDLE_PCT       = 11;
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 40;

   typedef logic [7:0] frame_bytes_type [FRAME_LEN];

   class sbus_channel_sb;
      logic [7:0]  frame_bytes [FRAME_LEN];
      int unsigned position;
      logic [15:0] bad_frames;
      logic [4:0]  channel_cfg;
      logic [15:0] gain;
      logic [15:0] offset;
      result_type  pending_channels [$];
      int unsigned errors;

      function new();
         position    = 0;
         bad_frames  = '0;
         channel_cfg = 5'd8;
         gain        = 16'd10240;
         offset      = 16'd880;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (csr_index_type'(idx))
            CSR_CHAN_CFG:     channel_cfg = data[4:0];
            CSR_SCALE_GAIN:   gain = data;
            CSR_SCALE_OFFSET: offset = data;
            default: ;
         endcase
      endfunction

      function void count_bad();
         if (bad_frames != 16'hFFFF) bad_frames++;
      endfunction

      function void take_byte(logic [7:0] b, logic gap);
         int unsigned n;
         int unsigned bitpos;
         int unsigned k;
         int unsigned s;
         logic [23:0] w;
         logic [10:0] raw;
         logic [31:0] prod;
         logic [15:0] scaled;
         logic [7:0]  flags;
         result_type  item;
         if (gap) begin
            if (position != 0) count_bad();
            position = 0;
         end
         frame_bytes[position] = b;
         position++;
         if (position < FRAME_LEN) return;
         position = 0;
         if (frame_bytes[0] != HEADER_BYTE || frame_bytes[FOOTER_POS] != FOOTER_BYTE) begin
            count_bad();
            return;
         end
         n = (channel_cfg > MAX_CHANNELS) ? MAX_CHANNELS : channel_cfg;
         flags = frame_bytes[FLAG_POS];
         for (int i = 0; i < n; i++) begin
            bitpos = RAW_WIDTH * i;
            k = FIRST_DATA_POS + bitpos / 8;
            s = bitpos % 8;
            w = {frame_bytes[k + 2], frame_bytes[k + 1], frame_bytes[k]};
            raw = RAW_WIDTH'(w >> s);
            prod = 32'(raw) * 32'(gain) + 32'(ROUND_BIAS);
            scaled = 16'(prod >> FRAC_BITS);
            item.index      = 4'(i);
            item.value      = scaled + offset;
            item.failsafe   = flags[FAILSAFE_BIT];
            item.frame_lost = flags[LOST_BIT];
            item.lost       = bad_frames;
            item.last       = (i + 1 == n);
            pending_channels.push_back(item);
         end
         bad_frames = '0;
      endfunction

      function void check_channel(result_type got);
         result_type exp;
         if (pending_channels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected item: idx=%0d val=%h fs=%b fl=%b lost=%0d last=%b",
                        got.index, got.value, got.failsafe, got.frame_lost, got.lost,
                        got.last);
            return;
         end
         exp = pending_channels.pop_front();
         if (got.index !== exp.index || got.value !== exp.value ||
             got.failsafe !== exp.failsafe || got.frame_lost !== exp.frame_lost ||
             got.lost !== exp.lost || got.last !== exp.last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp idx=%0d val=%h fs=%b fl=%b lost=%0d last=%b",
                        exp.index, exp.value, exp.failsafe, exp.frame_lost, exp.lost,
                        exp.last);
               $display("          got idx=%0d val=%h fs=%b fl=%b lost=%0d last=%b",
                        got.index, got.value, got.failsafe, got.frame_lost, got.lost,
                        got.last);
            end
         end
      endfunction

      function int outstanding();
         return pending_channels.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        req_gap_before = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_channel_index;
   logic [15:0] rsp_channel_value;
   logic        rsp_failsafe;
   logic        rsp_frame_lost;
   logic [15:0] rsp_lost_frames;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   sbus_channel_sb channel_sb = new();
   logic        quiet = 1'b0;
   logic        resync = 1'b0;
   int unsigned sent_items = 0;
   int unsigned stall_cycles = 0;

   sbus_frame_decoder_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .req_gap_before(req_gap_before),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_channel_index(rsp_channel_index),
      .rsp_channel_value(rsp_channel_value),
      .rsp_failsafe(rsp_failsafe),
      .rsp_frame_lost(rsp_frame_lost),
      .rsp_lost_frames(rsp_lost_frames),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   always @(negedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.index      = rsp_channel_index;
         got.value      = rsp_channel_value;
         got.failsafe   = rsp_failsafe;
         got.frame_lost = rsp_frame_lost;
         got.lost       = rsp_lost_frames;
         got.last       = rsp_last;
         channel_sb.check_channel(got);
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic gap);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_gap_before <= gap;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      channel_sb.take_byte(b, gap);
      sent_items++;
   endtask

   task automatic send_frame(input frame_bytes_type fr, input int unsigned len,
                             input logic lead_gap);
      for (int i = 0; i < len; i++)
         send_byte(fr[i], (i == 0) ? lead_gap : 1'b0);
   endtask

   function automatic frame_bytes_type good_frame();
      frame_bytes_type fr;
      int unsigned fill;
      fill = $urandom_range(3);
      fr[0] = HEADER_BYTE;
      for (int i = FIRST_DATA_POS; i < FLAG_POS; i++)
         fr[i] = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom_range(255));
      fr[FLAG_POS] = 8'($urandom_range(255));
      fr[FOOTER_POS] = FOOTER_BYTE;
      return fr;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      while (channel_sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      channel_sb.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [15:0] chans, input logic [15:0] gain,
                             input logic [15:0] offset);
      drain_results();
      write_csr(CSR_CHAN_CFG, chans);
      write_csr(CSR_UNUSED_INDEX, 16'($urandom_range(65535)));
      write_csr(CSR_SCALE_GAIN, gain);
      write_csr(CSR_SCALE_OFFSET, offset);
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int unsigned count);
      frame_bytes_type fr;
      int unsigned start;
      int unsigned pick;
      start = sent_items;
      while (sent_items - start < count) begin
         pick = $urandom_range(99);
         fr = good_frame();
         if (pick < 70) begin
            send_frame(fr, FRAME_LEN, resync ? 1'b1 : 1'($urandom_range(1)));
            resync = 1'b0;
         end else if (pick < 78) begin
            fr[0] = 8'($urandom_range(255));
            if (fr[0] == HEADER_BYTE) fr[0] = ~fr[0];
            send_frame(fr, FRAME_LEN, 1'b1);
         end else if (pick < 85) begin
            fr[FOOTER_POS] = 8'($urandom_range(1, 255));
            send_frame(fr, FRAME_LEN, 1'b1);
         end else if (pick < 93) begin
            send_frame(fr, $urandom_range(1, FRAME_LEN - 1), 1'b1);
            resync = 1'b1;
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            resync = 1'b1;
         end
      end
   endtask

   initial begin
      frame_bytes_type fr;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      fr[0] = HEADER_BYTE;
      for (int i = FIRST_DATA_POS; i < FLAG_POS; i++) fr[i] = 8'hFF;
      fr[FLAG_POS] = 8'h0C;
      fr[FOOTER_POS] = FOOTER_BYTE;
      send_frame(fr, FRAME_LEN, 1'b1);
      send_byte(HEADER_BYTE, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      drain_results();

      random_traffic(PHASE_ITEMS);
      quiet = 1'b1;
      set_config(16'd16, 16'hFFFF, 16'h7FFF);
      random_traffic(PHASE_ITEMS);
      set_config(16'd0, 16'h0000, 16'h8000);
      random_traffic(PHASE_ITEMS);
      quiet = 1'b0;
      set_config(16'hFFFF, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      random_traffic(PHASE_ITEMS);
      set_config(16'd1, 16'd16384, 16'h0000);
      random_traffic(PHASE_ITEMS);
      set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)));
      random_traffic(PHASE_ITEMS);

      set_config(16'd2, 16'd10240, 16'd880);
      fr = good_frame();
      fr[0] = ~HEADER_BYTE;
      send_frame(fr, FRAME_LEN, 1'b1);
      fr = good_frame();
      send_frame(fr, FRAME_LEN, 1'b1);

      drain_results();
      if (channel_sb.errors == 0 && channel_sb.outstanding() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
